>>> src/rbsc_pkg.sv
// Shared types, register indexes and single-precision helper functions for the slab clipper.
package rbsc_pkg;

  // Working widths for unrounded single-precision values.
  localparam int SIG_W = 27;
  localparam int EXP_W = 11;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef logic signed [EXP_W-1:0] exp_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BOX_MIN_X = 3'd0;
  localparam cfg_idx_t CFG_BOX_MIN_Y = 3'd1;
  localparam cfg_idx_t CFG_BOX_MIN_Z = 3'd2;
  localparam cfg_idx_t CFG_BOX_MAX_X = 3'd3;
  localparam cfg_idx_t CFG_BOX_MAX_Y = 3'd4;
  localparam cfg_idx_t CFG_BOX_MAX_Z = 3'd5;

  // Input word: one ray and its current interval.
  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] inv_dir_x;
    logic [31:0] inv_dir_y;
    logic [31:0] inv_dir_z;
    logic [31:0] t_enter_in;
    logic [31:0] t_exit_in;
  } rbsc_in_t;

  // Output word: hit flag and the clipped interval.
  typedef struct packed {
    logic        hit;
    logic [31:0] t_enter_out;
    logic [31:0] t_exit_out;
  } rbsc_out_t;

  // True for any NaN encoding.
  function automatic logic f_is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  // Ordered greater-than: false on NaN and on a pair of zeros.
  function automatic logic f_gt(input logic [31:0] p, input logic [31:0] q);
    logic r;
    if (f_is_nan(p) || f_is_nan(q)) begin
      r = 1'b0;
    end else if ((p[30:0] == 31'd0) && (q[30:0] == 31'd0)) begin
      r = 1'b0;
    end else if (p[31] != q[31]) begin
      r = !p[31];
    end else if (!p[31]) begin
      r = p[30:0] > q[30:0];
    end else begin
      r = p[30:0] < q[30:0];
    end
    return r;
  endfunction

  // Entry narrowing: keep the current value only when it is strictly larger.
  function automatic logic [31:0] pick_max(input logic [31:0] cur, input logic [31:0] d);
    return f_gt(cur, d) ? cur : d;
  endfunction

  // Exit narrowing: keep the current value only when it is strictly smaller.
  function automatic logic [31:0] pick_min(input logic [31:0] cur, input logic [31:0] d);
    return f_gt(d, cur) ? cur : d;
  endfunction

  // Right shift that folds every lost bit into the sticky bit.
  function automatic logic [SIG_W-1:0] shr_sticky(input logic [SIG_W-1:0] s,
                                                  input logic [5:0] amt);
    logic [SIG_W-1:0] mask;
    logic [SIG_W-1:0] r;
    mask = '0;
    if (amt >= 6'(SIG_W)) begin
      r = {{(SIG_W-1){1'b0}}, |s};
    end else begin
      mask = ~({SIG_W{1'b1}} << amt);
      r = s >> amt;
      r[0] = r[0] | (|(s & mask));
    end
    return r;
  endfunction

  // Leading-zero count of a nonzero significand.
  function automatic logic [4:0] lzc27(input logic [SIG_W-1:0] s);
    logic [4:0] n;
    logic       found;
    n = '0;
    found = 1'b0;
    for (int i = 0; i < SIG_W; i++) begin
      if (!found && s[SIG_W-1-i]) begin
        n = 5'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack. The significand has its leading one at the
  // top bit, then 23 fraction bits, a guard bit and two sticky bits.
  function automatic logic [31:0] round_pack(input logic sign, input exp_t e,
                                             input logic [SIG_W-1:0] sig);
    logic [SIG_W-1:0] s;
    logic [7:0]       ef;
    logic [30:0]      mag;
    logic             inc;
    exp_t             one_minus;
    logic [5:0]       sh;
    logic [31:0]      r;
    s = sig;
    ef = '0;
    one_minus = '0;
    sh = '0;
    if (e >= exp_t'(255)) begin
      r = {sign, 8'hFF, 23'd0};
    end else begin
      if (e < exp_t'(1)) begin
        // Subnormal result: shift back down to the fixed minimum exponent.
        one_minus = exp_t'(1) - e;
        sh = (one_minus > exp_t'(31)) ? 6'd31 : one_minus[5:0];
        s = shr_sticky(sig, sh);
        ef = 8'd0;
      end else begin
        ef = e[7:0];
      end
      inc = s[2] & (s[3] | s[1] | s[0]);
      mag = {ef, s[25:3]} + {30'd0, inc};
      r = {sign, mag};
    end
    return r;
  endfunction

endpackage

>>> src/rbsc_fadd.sv
// Three-stage single-precision adder: align and add, normalize, round.
module rbsc_fadd (
  input  logic        clk_i,
  input  logic [2:0]  en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] sum_o
);
  import rbsc_pkg::*;

  typedef struct packed {
    logic             nan;
    logic             inf;
    logic             inf_sign;
    logic             sign;
    logic             zsign;
    logic [7:0]       e;
    logic [SIG_W:0]   sum;
  } add1_t;

  typedef struct packed {
    logic             nan;
    logic             inf;
    logic             inf_sign;
    logic             sign;
    logic             zero;
    logic             zsign;
    exp_t             e;
    logic [SIG_W-1:0] sig;
  } add2_t;

  add1_t       s1_d, s1_q;
  add2_t       s2_d, s2_q;
  logic [31:0] sum_d, sum_q;

  logic             a_inf, b_inf, swap;
  logic [31:0]      x, y;
  logic [7:0]       ex, ey, diff;
  logic [5:0]       amt;
  logic [SIG_W-1:0] sx, sy, sy_al;
  logic [4:0]       lz;

  // Stage one: order by magnitude, align the smaller operand and add.
  always_comb begin
    a_inf = a_i[30:0] == {8'hFF, 23'd0};
    b_inf = b_i[30:0] == {8'hFF, 23'd0};
    swap  = b_i[30:0] > a_i[30:0];
    x     = swap ? b_i : a_i;
    y     = swap ? a_i : b_i;
    ex    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    sx    = {x[30:23] != 8'd0, x[22:0], 3'b000};
    sy    = {y[30:23] != 8'd0, y[22:0], 3'b000};
    diff  = ex - ey;
    amt   = (diff > 8'(SIG_W)) ? 6'(SIG_W) : diff[5:0];
    sy_al = shr_sticky(sy, amt);
    s1_d.nan      = f_is_nan(a_i) || f_is_nan(b_i) || (a_inf && b_inf && (a_i[31] != b_i[31]));
    s1_d.inf      = a_inf || b_inf;
    s1_d.inf_sign = a_inf ? a_i[31] : b_i[31];
    s1_d.sign     = x[31];
    s1_d.zsign    = x[31] & y[31];
    s1_d.e        = ex;
    s1_d.sum      = (x[31] == y[31]) ? ({1'b0, sx} + {1'b0, sy_al})
                                     : ({1'b0, sx} - {1'b0, sy_al});
  end

  // Stage two: bring the leading one to the top bit.
  always_comb begin
    lz = lzc27(s1_q.sum[SIG_W-1:0]);
    s2_d.nan      = s1_q.nan;
    s2_d.inf      = s1_q.inf;
    s2_d.inf_sign = s1_q.inf_sign;
    s2_d.sign     = s1_q.sign;
    s2_d.zsign    = s1_q.zsign;
    s2_d.zero     = 1'b0;
    priority if (s1_q.sum[SIG_W]) begin
      s2_d.sig = {s1_q.sum[SIG_W:2], |s1_q.sum[1:0]};
      s2_d.e   = exp_t'(s1_q.e) + exp_t'(1);
    end else if (s1_q.sum == '0) begin
      s2_d.sig  = '0;
      s2_d.e    = '0;
      s2_d.zero = 1'b1;
    end else begin
      s2_d.sig = s1_q.sum[SIG_W-1:0] << lz;
      s2_d.e   = exp_t'(s1_q.e) - exp_t'(lz);
    end
  end

  // Stage three: special values, then rounding.
  always_comb begin
    priority if (s2_q.nan) begin
      sum_d = CANON_NAN;
    end else if (s2_q.inf) begin
      sum_d = {s2_q.inf_sign, 8'hFF, 23'd0};
    end else if (s2_q.zero) begin
      sum_d = {s2_q.zsign, 31'd0};
    end else begin
      sum_d = round_pack(s2_q.sign, s2_q.e, s2_q.sig);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q <= s1_d;
    end
    if (en_i[1]) begin
      s2_q <= s2_d;
    end
    if (en_i[2]) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

>>> src/rbsc_fmul.sv
// Three-stage single-precision multiplier: unpack, multiply, normalize and round.
module rbsc_fmul (
  input  logic        clk_i,
  input  logic [2:0]  en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] prod_o
);
  import rbsc_pkg::*;

  typedef struct packed {
    exp_t        e;
    logic [23:0] m;
  } op_t;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    exp_t        ea;
    exp_t        eb;
    logic [23:0] ma;
    logic [23:0] mb;
  } mul1_t;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    exp_t        e;
    logic [47:0] prod;
  } mul2_t;

  // Subnormal operands get their leading one moved to the top bit.
  function automatic op_t prenorm(input logic [31:0] f);
    op_t        r;
    logic [4:0] lz;
    lz = lzc27({1'b0, f[22:0], 3'b111});
    if (f[30:23] != 8'd0) begin
      r.e = exp_t'(f[30:23]);
      r.m = {1'b1, f[22:0]};
    end else begin
      r.m = {1'b0, f[22:0]} << lz;
      r.e = exp_t'(1) - exp_t'(lz);
    end
    return r;
  endfunction

  mul1_t       s1_d, s1_q;
  mul2_t       s2_d, s2_q;
  logic [31:0] prod_d, prod_q;

  logic             a_inf, b_inf, a_zero, b_zero;
  op_t              oa, ob;
  logic [SIG_W-1:0] sig;
  exp_t             e3;

  // Stage one: classify and unpack both operands.
  always_comb begin
    a_inf  = a_i[30:0] == {8'hFF, 23'd0};
    b_inf  = b_i[30:0] == {8'hFF, 23'd0};
    a_zero = a_i[30:0] == 31'd0;
    b_zero = b_i[30:0] == 31'd0;
    oa     = prenorm(a_i);
    ob     = prenorm(b_i);
    s1_d.nan  = f_is_nan(a_i) || f_is_nan(b_i) || (a_inf && b_zero) || (a_zero && b_inf);
    s1_d.inf  = a_inf || b_inf;
    s1_d.zero = a_zero || b_zero;
    s1_d.sign = a_i[31] ^ b_i[31];
    s1_d.ea   = oa.e;
    s1_d.eb   = ob.e;
    s1_d.ma   = oa.m;
    s1_d.mb   = ob.m;
  end

  // Stage two: significand product and exponent sum.
  always_comb begin
    s2_d.nan  = s1_q.nan;
    s2_d.inf  = s1_q.inf;
    s2_d.zero = s1_q.zero;
    s2_d.sign = s1_q.sign;
    s2_d.e    = s1_q.ea + s1_q.eb - exp_t'(127);
    s2_d.prod = 48'(s1_q.ma) * 48'(s1_q.mb);
  end

  // Stage three: one-bit normalize, special values, rounding.
  always_comb begin
    if (s2_q.prod[47]) begin
      sig = {s2_q.prod[47:22], |s2_q.prod[21:0]};
      e3  = s2_q.e + exp_t'(1);
    end else begin
      sig = {s2_q.prod[46:21], |s2_q.prod[20:0]};
      e3  = s2_q.e;
    end
    priority if (s2_q.nan) begin
      prod_d = CANON_NAN;
    end else if (s2_q.inf) begin
      prod_d = {s2_q.sign, 8'hFF, 23'd0};
    end else if (s2_q.zero) begin
      prod_d = {s2_q.sign, 31'd0};
    end else begin
      prod_d = round_pack(s2_q.sign, e3, sig);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q <= s1_d;
    end
    if (en_i[1]) begin
      s2_q <= s2_d;
    end
    if (en_i[2]) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> src/ray_box_slab_clip.sv
// Top level of the ray versus axis-aligned box slab clipper.
//
//  channel  direction  handshake               word
//  in       input      in_valid_i / in_stall_o   rbsc_in_t: origin, inverse direction, interval
//  out      output     out_valid_o / out_stall_i rbsc_out_t: hit, clipped interval
//  cfg      input      cfg_valid_i / cfg_ready_o index and data of one box bound
//
// Nine register stages: subtract (3), multiply (3), order and narrow x (1), narrow y and z (1),
// final test (1). A word enters every cycle unless in_stall_o is high.
// Each stage moves when the stage after it is empty or moving, so bubbles close up and a stall
// on the output raises in_stall_o only once every stage holds a word.
// Reset clears the stage valid bits and sets all box bounds to +0.0.
// The configuration port is always ready; bounds feed the first stage directly.
module ray_box_slab_clip (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rbsc_pkg::rbsc_in_t     in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rbsc_pkg::rbsc_out_t    out_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  rbsc_pkg::cfg_idx_t     cfg_index_i,
  input  logic [31:0]            cfg_data_i
);
  import rbsc_pkg::*;

  localparam int STAGES = 9;

  typedef struct packed {
    logic [31:0] t_enter;
    logic [31:0] t_exit;
  } span_t;

  logic [31:0]       box_min_q [3];
  logic [31:0]       box_max_q [3];
  logic [STAGES:1]   v_q;
  logic [STAGES:1]   en;
  logic [2:0][31:0]  org_neg;
  logic [2:0][31:0]  inv_q [1:3];
  span_t             span_q [1:8];
  logic [31:0]       d_lo [3];
  logic [31:0]       d_hi [3];
  logic [31:0]       t_lo [3];
  logic [31:0]       t_hi [3];
  logic [31:0]       near_t [3];
  logic [31:0]       far_t [3];
  logic [31:0]       ent7_d, ext7_d, ent7_q, ext7_q;
  logic [31:0]       near7_q [1:2];
  logic [31:0]       far7_q [1:2];
  logic [31:0]       ent_y, ext_y, ent8_d, ext8_d, ent8_q, ext8_q;
  rbsc_out_t         res_d, res_q;
  logic              miss;

  // Configuration writes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_min_q[i] <= '0;
        box_max_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BOX_MIN_X: box_min_q[0] <= cfg_data_i;
        CFG_BOX_MIN_Y: box_min_q[1] <= cfg_data_i;
        CFG_BOX_MIN_Z: box_min_q[2] <= cfg_data_i;
        CFG_BOX_MAX_X: box_max_q[0] <= cfg_data_i;
        CFG_BOX_MAX_Y: box_max_q[1] <= cfg_data_i;
        CFG_BOX_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[STAGES] = !v_q[STAGES] || !out_stall_i;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[STAGES];
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Words that ride alongside the arithmetic.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      inv_q[1]  <= {in_i.inv_dir_z, in_i.inv_dir_y, in_i.inv_dir_x};
      span_q[1] <= {in_i.t_enter_in, in_i.t_exit_in};
    end
    for (int k = 2; k <= 3; k++) begin
      if (en[k]) begin
        inv_q[k] <= inv_q[k-1];
      end
    end
    for (int k = 2; k <= 8; k++) begin
      if (en[k]) begin
        span_q[k] <= span_q[k-1];
      end
    end
  end

  // Slab distances per axis: (bound - origin) * inverse direction.
  assign org_neg[0] = {~in_i.origin_x[31], in_i.origin_x[30:0]};
  assign org_neg[1] = {~in_i.origin_y[31], in_i.origin_y[30:0]};
  assign org_neg[2] = {~in_i.origin_z[31], in_i.origin_z[30:0]};

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    rbsc_fadd u_sub_lo (
      .clk_i (clk_i),
      .en_i  (en[3:1]),
      .a_i   (box_min_q[ax]),
      .b_i   (org_neg[ax]),
      .sum_o (d_lo[ax])
    );
    rbsc_fadd u_sub_hi (
      .clk_i (clk_i),
      .en_i  (en[3:1]),
      .a_i   (box_max_q[ax]),
      .b_i   (org_neg[ax]),
      .sum_o (d_hi[ax])
    );
    rbsc_fmul u_mul_lo (
      .clk_i  (clk_i),
      .en_i   (en[6:4]),
      .a_i    (d_lo[ax]),
      .b_i    (inv_q[3][ax]),
      .prod_o (t_lo[ax])
    );
    rbsc_fmul u_mul_hi (
      .clk_i  (clk_i),
      .en_i   (en[6:4]),
      .a_i    (d_hi[ax]),
      .b_i    (inv_q[3][ax]),
      .prod_o (t_hi[ax])
    );
  end

  // Stage seven: order each pair and narrow by the x slab.
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      near_t[ax] = f_gt(t_lo[ax], t_hi[ax]) ? t_hi[ax] : t_lo[ax];
      far_t[ax]  = f_gt(t_lo[ax], t_hi[ax]) ? t_lo[ax] : t_hi[ax];
    end
    ent7_d = pick_max(span_q[6].t_enter, near_t[0]);
    ext7_d = pick_min(span_q[6].t_exit, far_t[0]);
  end

  // Stage eight: narrow by the y and then the z slab.
  always_comb begin
    ent_y  = pick_max(ent7_q, near7_q[1]);
    ext_y  = pick_min(ext7_q, far7_q[1]);
    ent8_d = pick_max(ent_y, near7_q[2]);
    ext8_d = pick_min(ext_y, far7_q[2]);
  end

  // Stage nine: miss test, canonical NaN on a hit.
  always_comb begin
    miss = f_gt(ent8_q, ext8_q);
    if (miss) begin
      res_d.hit         = 1'b0;
      res_d.t_enter_out = span_q[8].t_enter;
      res_d.t_exit_out  = span_q[8].t_exit;
    end else begin
      res_d.hit         = 1'b1;
      res_d.t_enter_out = f_is_nan(ent8_q) ? CANON_NAN : ent8_q;
      res_d.t_exit_out  = f_is_nan(ext8_q) ? CANON_NAN : ext8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      ent7_q     <= ent7_d;
      ext7_q     <= ext7_d;
      near7_q[1] <= near_t[1];
      near7_q[2] <= near_t[2];
      far7_q[1]  <= far_t[1];
      far7_q[2]  <= far_t[2];
    end
    if (en[8]) begin
      ent8_q <= ent8_d;
      ext8_q <= ext8_d;
    end
    if (en[9]) begin
      res_q <= res_d;
    end
  end

`ifndef ASSERT_OFF
  // A full pipe with a stalled output must push back on the input.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && out_stall_i) |-> in_stall_o)
    else $error("full pipeline did not stall the input");

  // An empty first stage always takes a word.
  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[1] |-> !in_stall_o)
    else $error("input stalled with an empty first stage");

  // A held word in the middle of the pipe is not dropped.
  a_hold_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[5] && !en[6]) |=> v_q[5])
    else $error("word lost in the multiplier stage");

  // A hit never shows a NaN other than the canonical one in t_enter_out.
  a_canon_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.hit && f_is_nan(out_o.t_enter_out)) |->
      (out_o.t_enter_out == CANON_NAN))
    else $error("non-canonical NaN on a hit");
`endif

endmodule
